// ----- hdl/rsp_pkg.sv -----
// shared types, constants and helpers for the sprite projection unit
package rsp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIFF_W      = 50;
    localparam int DET_W       = 33;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 128;

    typedef enum logic [2:0] {
        REG_DIR_X    = 3'd0,
        REG_DIR_Y    = 3'd1,
        REG_PLANE_X  = 3'd2,
        REG_PLANE_Y  = 3'd3,
        REG_CAMERA_X = 3'd4,
        REG_CAMERA_Y = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } rsp_reg_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic [11:0]        width;
        logic [11:0]        height;
    } rsp_cfg_t;

    typedef struct packed {
        logic                      kill;
        logic signed [DIFF_W-1:0]  diff_x;
        logic signed [DIFF_W-1:0]  diff_y;
        logic signed [11:0]        voff;
    } rsp_item_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/raycast_sprite_projection_unit.sv -----
// top level: register file, front end, queue and projection back end
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------------
//  s_       | in        | tdata: sprite_x, sprite_y, view_offset
//  m_       | out       | tdata: depth .. sprite_size, tuser: visible
//  apb      | in/out    | eight camera and screen registers at 4*index
//
//  one sprite is accepted per cycle while the queue has room; the pipeline depth is
//  set by the two 62-stage dividers in the back end
//  reset is synchronous on aresetn low and clears all valid flags and the queue
//  a stalled m_ side freezes the back end; the four-entry queue lets the front end
//  keep taking sprites until it fills
module raycast_sprite_projection_unit #(
    parameter int TILE_UNITS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // sprite_x [31:0], sprite_y [63:32], view_offset [75:64]
    input  logic [rsp_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // depth [31:0], center_column [47:32], first_column [63:48], end_column [79:64],
    // top_row [95:80], bottom_row [111:96], sprite_size [126:112]
    output logic [rsp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // visible [0]
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [4:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    localparam int LIMIT = (TILE_UNITS * 65536 + 9) / 10;

    rsp_pkg::rsp_cfg_t  cfg_reg;
    rsp_pkg::rsp_reg_t  reg_sel;
    rsp_pkg::rsp_item_t q_item, q_head;
    logic q_push, q_full, q_pop, q_empty, wr_en;
    logic signed [rsp_pkg::DET_W-1:0] det;

    assign pready  = 1'b1;
    assign reg_sel = rsp_pkg::rsp_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dir_x    <= 16'sd16384;
            cfg_reg.dir_y    <= '0;
            cfg_reg.plane_x  <= '0;
            cfg_reg.plane_y  <= 16'sd10813;
            cfg_reg.camera_x <= '0;
            cfg_reg.camera_y <= '0;
            cfg_reg.width    <= 12'd800;
            cfg_reg.height   <= 12'd600;
        end else if (wr_en) begin
            unique case (reg_sel)
                rsp_pkg::REG_DIR_X:    cfg_reg.dir_x    <= pwdata[15:0];
                rsp_pkg::REG_DIR_Y:    cfg_reg.dir_y    <= pwdata[15:0];
                rsp_pkg::REG_PLANE_X:  cfg_reg.plane_x  <= pwdata[15:0];
                rsp_pkg::REG_PLANE_Y:  cfg_reg.plane_y  <= pwdata[15:0];
                rsp_pkg::REG_CAMERA_X: cfg_reg.camera_x <= pwdata;
                rsp_pkg::REG_CAMERA_Y: cfg_reg.camera_y <= pwdata;
                rsp_pkg::REG_WIDTH:    cfg_reg.width    <= pwdata[11:0];
                rsp_pkg::REG_HEIGHT:   cfg_reg.height   <= pwdata[11:0];
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            rsp_pkg::REG_DIR_X:    prdata = {16'b0, cfg_reg.dir_x};
            rsp_pkg::REG_DIR_Y:    prdata = {16'b0, cfg_reg.dir_y};
            rsp_pkg::REG_PLANE_X:  prdata = {16'b0, cfg_reg.plane_x};
            rsp_pkg::REG_PLANE_Y:  prdata = {16'b0, cfg_reg.plane_y};
            rsp_pkg::REG_CAMERA_X: prdata = cfg_reg.camera_x;
            rsp_pkg::REG_CAMERA_Y: prdata = cfg_reg.camera_y;
            rsp_pkg::REG_WIDTH:    prdata = {20'b0, cfg_reg.width};
            rsp_pkg::REG_HEIGHT:   prdata = {20'b0, cfg_reg.height};
            default:               prdata = '0;
        endcase
    end

    rsp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_item   (q_item),
        .q_full   (q_full),
        .det      (det)
    );

    rsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    rsp_back #(.TILE_UNITS(TILE_UNITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .det      (det),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("hidden sprite carries nonzero fields");

    a_depth_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ($signed(m_tdata[31:0]) >= LIMIT))
        else $error("visible sprite closer than near limit");

    a_column_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (($signed(m_tdata[63:48]) <= $signed(m_tdata[47:32]))
                                 && ($signed(m_tdata[47:32]) <= $signed(m_tdata[79:64]))))
        else $error("column span out of order");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ($signed(m_tdata[95:80]) <= $signed(m_tdata[111:96])))
        else $error("row span out of order");

endmodule

// ----- hdl/rsp_queue.sv -----
// small fifo between the classifying front end and the projection back end
module rsp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rsp_pkg::rsp_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output rsp_pkg::rsp_item_t head
);
    localparam int AW = $clog2(rsp_pkg::QUEUE_DEPTH);

    rsp_pkg::rsp_item_t mem_reg [rsp_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(rsp_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/rsp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, two dividends share one divisor
module rsp_div #(
    parameter int NW = 62,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num_a,
    input  logic [NW-1:0] in_num_b,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo_a,
    output logic [DW-1:0] out_rem_a,
    output logic [NW-1:0] out_quo_b,
    output logic [DW-1:0] out_den,
    output logic [SW-1:0] out_side
);
    logic          vld_reg  [NW];
    logic [NW-1:0] a_reg    [NW];
    logic [NW-1:0] b_reg    [NW];
    logic [DW-1:0] ra_reg   [NW];
    logic [DW-1:0] rb_reg   [NW];
    logic [DW-1:0] d_reg    [NW];
    logic [SW-1:0] s_reg    [NW];

    genvar k;
    for (k = 0; k < NW; k++) begin : g_stage
        logic          v_i;
        logic [NW-1:0] a_i, b_i;
        logic [DW-1:0] ra_i, rb_i, d_i;
        logic [SW-1:0] s_i;
        logic [DW:0]   ta, tb, sa, sb;
        logic          ga, gb;

        if (k == 0) begin : g_first
            assign v_i  = in_valid;
            assign a_i  = in_num_a;
            assign b_i  = in_num_b;
            assign ra_i = '0;
            assign rb_i = '0;
            assign d_i  = in_den;
            assign s_i  = in_side;
        end else begin : g_next
            assign v_i  = vld_reg[k-1];
            assign a_i  = a_reg[k-1];
            assign b_i  = b_reg[k-1];
            assign ra_i = ra_reg[k-1];
            assign rb_i = rb_reg[k-1];
            assign d_i  = d_reg[k-1];
            assign s_i  = s_reg[k-1];
        end

        // shift the next dividend bit into the partial remainder
        assign ta = {ra_i, a_i[NW-1]};
        assign tb = {rb_i, b_i[NW-1]};
        assign sa = ta - {1'b0, d_i};
        assign sb = tb - {1'b0, d_i};
        assign ga = (ta >= {1'b0, d_i});
        assign gb = (tb >= {1'b0, d_i});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ra_reg[k] <= ga ? sa[DW-1:0] : ta[DW-1:0];
                rb_reg[k] <= gb ? sb[DW-1:0] : tb[DW-1:0];
                a_reg[k]  <= {a_i[NW-2:0], ga};
                b_reg[k]  <= {b_i[NW-2:0], gb};
                d_reg[k]  <= d_i;
                s_reg[k]  <= s_i;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo_a = a_reg[NW-1];
    assign out_rem_a = ra_reg[NW-1];
    assign out_quo_b = b_reg[NW-1];
    assign out_den   = d_reg[NW-1];
    assign out_side  = s_reg[NW-1];

endmodule

// ----- hdl/rsp_front.sv -----
// front end: takes sprite positions, forms the camera-space numerators, flags singular cameras
module rsp_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rsp_pkg::rsp_cfg_t                cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rsp_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             q_push,
    output rsp_pkg::rsp_item_t               q_item,
    input  logic                             q_full,
    output logic signed [rsp_pkg::DET_W-1:0] det
);
    logic adv;
    logic f1_v_reg, f2_v_reg, f3_v_reg;

    logic signed [32:0] rx_reg, ry_reg;
    logic signed [11:0] voff1_reg, voff2_reg, voff3_reg;
    logic signed [48:0] pyx_reg, pxy_reg, pxr_reg, pyr_reg;
    logic signed [rsp_pkg::DIFF_W-1:0] dx_reg, dy_reg;
    logic kill_reg;

    logic signed [31:0] dp1_reg, dp2_reg;
    logic signed [rsp_pkg::DET_W-1:0] det_reg;

    logic signed [31:0] sx, sy;
    assign sx = s_tdata[31:0];
    assign sy = s_tdata[63:32];

    assign adv      = !(f3_v_reg && q_full);
    assign s_tready = adv;
    assign q_push   = f3_v_reg && !q_full;
    assign q_item   = '{kill: kill_reg, diff_x: dx_reg, diff_y: dy_reg, voff: voff3_reg};
    assign det      = det_reg;

    // determinant follows the camera registers through the product registers and det_reg
    always_ff @(posedge aclk) begin
        dp1_reg <= $signed(cfg.plane_x) * $signed(cfg.dir_y);
        dp2_reg <= $signed(cfg.dir_x) * $signed(cfg.plane_y);
        det_reg <= {dp1_reg[31], dp1_reg} - {dp2_reg[31], dp2_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else if (adv) begin
            f1_v_reg <= s_tvalid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rx_reg    <= {sx[31], sx} - {cfg.camera_x[31], cfg.camera_x};
            ry_reg    <= {sy[31], sy} - {cfg.camera_y[31], cfg.camera_y};
            voff1_reg <= s_tdata[75:64];

            pyx_reg   <= $signed(cfg.dir_y) * rx_reg;
            pxy_reg   <= $signed(cfg.dir_x) * ry_reg;
            pxr_reg   <= $signed(cfg.plane_x) * ry_reg;
            pyr_reg   <= $signed(cfg.plane_y) * rx_reg;
            voff2_reg <= voff1_reg;

            dx_reg    <= {pyx_reg[48], pyx_reg} - {pxy_reg[48], pxy_reg};
            dy_reg    <= {pxr_reg[48], pxr_reg} - {pyr_reg[48], pyr_reg};
            kill_reg  <= (det_reg == '0);
            voff3_reg <= voff2_reg;
        end
    end

endmodule

// ----- hdl/rsp_back.sv -----
// back end: divisions, centre column fraction, spans and saturation of the result
module rsp_back #(
    parameter int TILE_UNITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rsp_pkg::rsp_cfg_t                  cfg,
    input  logic signed [rsp_pkg::DET_W-1:0]   det,
    input  logic                               q_empty,
    input  rsp_pkg::rsp_item_t                 q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rsp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);
    localparam int NUM_W  = 62;
    localparam int DEN1_W = 32;
    localparam int HALF_W = 11;
    localparam int SZ_W   = 16;
    localparam int FR_N   = 2 * HALF_W;
    localparam int TILE_W = $clog2(TILE_UNITS + 1);
    localparam int HT_W   = 12 + TILE_W;
    localparam int LIMIT  = (TILE_UNITS * 65536 + 9) / 10;

    typedef struct packed {
        logic               kill;
        logic               sx;
        logic               sy;
        logic signed [11:0] voff;
    } side1_t;

    typedef struct packed {
        logic               vis;
        logic               negx;
        logic signed [11:0] voff;
        logic [31:0]        depth;
    } side2_t;

    typedef struct packed {
        logic               vis;
        logic               negx;
        logic signed [11:0] voff;
        logic [31:0]        depth;
        logic [SZ_W-1:0]    sz;
        logic               ovf;
        logic [29:0]        ip;
    } side3_t;

    logic en;
    logic [HALF_W-1:0] half;
    assign en    = !m_tvalid || m_tready;
    assign q_pop = en && !q_empty;
    assign half  = cfg.width[11:1];

    // ---------------- operand preparation
    logic              b0_v_reg;
    logic [NUM_W-1:0]  b0_na_reg, b0_nb_reg;
    logic [DEN1_W-1:0] b0_den_reg;
    side1_t            b0_side_reg;
    logic [rsp_pkg::DIFF_W-1:0] mag_x, mag_y;
    logic [rsp_pkg::DET_W-1:0]  mag_det;

    assign mag_x   = q_head.diff_x[rsp_pkg::DIFF_W-1] ? -q_head.diff_x : q_head.diff_x;
    assign mag_y   = q_head.diff_y[rsp_pkg::DIFF_W-1] ? -q_head.diff_y : q_head.diff_y;
    assign mag_det = det[rsp_pkg::DET_W-1] ? -det : det;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_v_reg <= 1'b0;
        end else if (en) begin
            b0_v_reg <= q_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b0_na_reg   <= {mag_x[47:0], 14'b0};
            b0_nb_reg   <= {mag_y[47:0], 14'b0};
            b0_den_reg  <= mag_det[DEN1_W-1:0];
            b0_side_reg <= '{kill: q_head.kill,
                             sx:   q_head.diff_x[rsp_pkg::DIFF_W-1] ^ det[rsp_pkg::DET_W-1],
                             sy:   q_head.diff_y[rsp_pkg::DIFF_W-1] ^ det[rsp_pkg::DET_W-1],
                             voff: q_head.voff};
        end
    end

    // ---------------- camera-space x and depth
    logic                    d1_v;
    logic [NUM_W-1:0]        d1_qx, d1_qy;
    logic [DEN1_W-1:0]       d1_den;
    logic [$bits(side1_t)-1:0] d1_side_vec;
    side1_t                  d1_side;

    rsp_div #(.NW(NUM_W), .DW(DEN1_W), .SW($bits(side1_t))) u_div_cam (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b0_v_reg),
        .in_num_a  (b0_na_reg),
        .in_num_b  (b0_nb_reg),
        .in_den    (b0_den_reg),
        .in_side   (b0_side_reg),
        .out_valid (d1_v),
        .out_quo_a (d1_qx),
        .out_rem_a (),
        .out_quo_b (d1_qy),
        .out_den   (d1_den),
        .out_side  (d1_side_vec)
    );
    assign d1_side = side1_t'(d1_side_vec);

    // ---------------- near-limit test and second divide operands
    logic             b1_v_reg;
    logic [NUM_W-1:0] b1_a_reg, b1_szn_reg, b1_d_reg;
    side2_t           b1_side_reg;
    logic [HT_W-1:0]  ht;
    logic             d1_big;

    assign ht     = HT_W'(cfg.height) * HT_W'(TILE_UNITS);
    assign d1_big = (d1_qy[NUM_W-1:31] != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg <= 1'b0;
        end else if (en) begin
            b1_v_reg <= d1_v;
        end
    end

    // a singular camera also leaves d1_den at zero, the kill flag covers it
    always_ff @(posedge aclk) begin
        if (en) begin
            b1_a_reg    <= d1_qx;
            b1_d_reg    <= d1_qy;
            b1_szn_reg  <= NUM_W'({ht, 16'b0});
            b1_side_reg <= '{vis:   !d1_side.kill && (d1_den != '0) && !d1_side.sy
                                    && (d1_qy >= NUM_W'(LIMIT)),
                             negx:  d1_side.sx,
                             voff:  d1_side.voff,
                             depth: d1_big ? 32'h7fff_ffff : d1_qy[31:0]};
        end
    end

    // ---------------- integer ratio and projected size
    logic                      d2_v;
    logic [NUM_W-1:0]          d2_ip, d2_rem, d2_sz, d2_d;
    logic [$bits(side2_t)-1:0] d2_side_vec;
    side2_t                    d2_side;
    side3_t                    d2_s3;

    rsp_div #(.NW(NUM_W), .DW(NUM_W), .SW($bits(side2_t))) u_div_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b1_v_reg),
        .in_num_a  (b1_a_reg),
        .in_num_b  (b1_szn_reg),
        .in_den    (b1_d_reg),
        .in_side   (b1_side_reg),
        .out_valid (d2_v),
        .out_quo_a (d2_ip),
        .out_rem_a (d2_rem),
        .out_quo_b (d2_sz),
        .out_den   (d2_d),
        .out_side  (d2_side_vec)
    );
    assign d2_side = side2_t'(d2_side_vec);
    assign d2_s3   = '{vis:   d2_side.vis,
                       negx:  d2_side.negx,
                       voff:  d2_side.voff,
                       depth: d2_side.depth,
                       sz:    d2_sz[SZ_W-1:0],
                       ovf:   (d2_ip[NUM_W-1:30] != '0),
                       ip:    d2_ip[29:0]};

    // ---------------- floor(half * rem / d), one half-width bit per two stages
    logic              fr_v_reg   [FR_N];
    logic [NUM_W-1:0]  fr_rem_reg [FR_N];
    logic [NUM_W-1:0]  fr_r_reg   [FR_N];
    logic [NUM_W-1:0]  fr_d_reg   [FR_N];
    logic [HALF_W-1:0] fr_q_reg   [FR_N];
    side3_t            fr_s_reg   [FR_N];

    genvar k;
    for (k = 0; k < FR_N; k++) begin : g_frac
        logic              v_i;
        logic [NUM_W-1:0]  rem_i, r_i, d_i, rem_o;
        logic [HALF_W-1:0] q_i, q_o;
        side3_t            s_i;
        logic [NUM_W:0]    t, sub;
        logic              ge;

        if (k == 0) begin : g_first
            assign v_i   = d2_v;
            assign rem_i = '0;
            assign r_i   = d2_rem;
            assign d_i   = d2_d;
            assign q_i   = '0;
            assign s_i   = d2_s3;
        end else begin : g_next
            assign v_i   = fr_v_reg[k-1];
            assign rem_i = fr_rem_reg[k-1];
            assign r_i   = fr_r_reg[k-1];
            assign d_i   = fr_d_reg[k-1];
            assign q_i   = fr_q_reg[k-1];
            assign s_i   = fr_s_reg[k-1];
        end

        if (k % 2 == 0) begin : g_dbl
            assign t   = {rem_i, 1'b0};
            assign ge  = (t >= {1'b0, d_i});
            assign q_o = {q_i[HALF_W-2:0], ge};
        end else begin : g_add
            assign t   = half[HALF_W-1-k/2] ? ({1'b0, rem_i} + {1'b0, r_i}) : {1'b0, rem_i};
            assign ge  = half[HALF_W-1-k/2] && (t >= {1'b0, d_i});
            assign q_o = q_i + {{(HALF_W-1){1'b0}}, ge};
        end

        assign sub   = t - {1'b0, d_i};
        assign rem_o = ge ? sub[NUM_W-1:0] : t[NUM_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fr_v_reg[k] <= 1'b0;
            end else if (en) begin
                fr_v_reg[k] <= v_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                fr_rem_reg[k] <= rem_o;
                fr_r_reg[k]   <= r_i;
                fr_d_reg[k]   <= d_i;
                fr_q_reg[k]   <= q_o;
                fr_s_reg[k]   <= s_i;
            end
        end
    end

    side3_t fr_s;
    assign fr_s = fr_s_reg[FR_N-1];

    // ---------------- column magnitude, centre column and bottom row
    logic              b3_v_reg, b4_v_reg, b5_v_reg;
    logic [40:0]       b3_prod_reg;
    logic [HALF_W-1:0] b3_fq_reg;
    logic              b3_inexact_reg;
    side3_t            b3_s_reg, b4_s_reg, b5_s_reg;
    logic [42:0]       b4_mag_reg;
    logic              b4_inexact_reg;
    logic signed [44:0] b5_centre_reg;
    logic signed [19:0] b5_bottom_reg;

    logic [44:0]        half45, mag45, p45;
    logic signed [44:0] hp, hm, hs, centre;
    logic signed [19:0] bottom;

    assign half45 = {34'b0, half};
    assign mag45  = {2'b0, b4_mag_reg};
    assign p45    = mag45 + {44'b0, b4_inexact_reg};
    assign hp     = half45 - p45;
    assign hm     = half45 - mag45;
    assign hs     = half45 + mag45;

    always_comb begin
        if (half == '0) begin
            centre = '0;
        end else if (!b4_s_reg.negx) begin
            centre = hs;
        end else if (!hp[44]) begin
            centre = hp;
        end else begin
            centre = hm;
        end
    end

    assign bottom = {9'b0, cfg.height[11:1]} + {{8{b4_s_reg.voff[11]}}, b4_s_reg.voff}
                    + {5'b0, b4_s_reg.sz[SZ_W-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            b5_v_reg <= 1'b0;
        end else if (en) begin
            b3_v_reg <= fr_v_reg[FR_N-1];
            b4_v_reg <= b3_v_reg;
            b5_v_reg <= b4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b3_prod_reg    <= {30'b0, half} * {11'b0, fr_s.ip};
            b3_fq_reg      <= fr_q_reg[FR_N-1];
            b3_inexact_reg <= fr_s.ovf || (fr_rem_reg[FR_N-1] != '0);
            b3_s_reg       <= fr_s;

            b4_mag_reg     <= b3_s_reg.ovf ? {1'b1, 42'b0}
                                           : {2'b0, b3_prod_reg} + {32'b0, b3_fq_reg};
            b4_inexact_reg <= b3_inexact_reg;
            b4_s_reg       <= b3_s_reg;

            b5_centre_reg  <= centre;
            b5_bottom_reg  <= bottom;
            b5_s_reg       <= b4_s_reg;
        end
    end

    // ---------------- spans, saturation and output register
    logic signed [47:0] c48, b48, hsz48, sz48;
    logic signed [15:0] o_centre, o_first, o_end, o_top, o_bottom;
    logic [14:0]        o_size;
    logic               m_valid_reg, m_user_reg;
    logic [rsp_pkg::OUT_DATA_W-1:0] m_data_reg;

    assign c48      = {{3{b5_centre_reg[44]}}, b5_centre_reg};
    assign b48      = {{28{b5_bottom_reg[19]}}, b5_bottom_reg};
    assign hsz48    = {33'b0, b5_s_reg.sz[SZ_W-1:1]};
    assign sz48     = {32'b0, b5_s_reg.sz};
    assign o_centre = rsp_pkg::sat16(c48);
    assign o_first  = rsp_pkg::sat16(c48 - hsz48);
    assign o_end    = rsp_pkg::sat16(c48 + hsz48);
    assign o_top    = rsp_pkg::sat16(b48 - sz48);
    assign o_bottom = rsp_pkg::sat16(b48);
    assign o_size   = b5_s_reg.sz[SZ_W-1] ? 15'h7fff : b5_s_reg.sz[14:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= b5_v_reg;
        end
    end

    // hidden sprites leave every field at zero
    always_ff @(posedge aclk) begin
        if (en) begin
            m_user_reg <= b5_s_reg.vis;
            if (b5_s_reg.vis) begin
                m_data_reg <= {1'b0, o_size, o_bottom, o_top, o_end, o_first, o_centre,
                               b5_s_reg.depth};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- test/tb.sv -----
// self-checking testbench for the sprite projection unit
`timescale 1ns / 100ps

module tb;

    localparam int TILE       = 64;
    localparam int MAX_CYCLES = 400000;
    localparam int N_RANDOM   = 530;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] depth;
        logic signed [15:0] center_column;
        logic signed [15:0] first_column;
        logic signed [15:0] end_column;
        logic signed [15:0] top_row;
        logic signed [15:0] bottom_row;
        logic [14:0]        sprite_size;
    } projection_t;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [11:0] voff;
        logic               typed;
        projection_t        want;
    } sprite_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [rsp_pkg::IN_DATA_W-1:0]       s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [rsp_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic                                m_tuser;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [4:0]                          paddr = '0;
    logic [31:0]                         pwdata = '0;
    logic [31:0]                         prdata;
    logic                                pready;

    raycast_sprite_projection_unit #(.TILE_UNITS(TILE)) DUT (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // camera copy kept beside the block
    logic signed [15:0] cam_dir_x = 16384, cam_dir_y = 0, cam_plane_x = 0, cam_plane_y = 10813;
    logic signed [31:0] cam_pos_x = 0, cam_pos_y = 0;
    logic [11:0]        scr_width = 800, scr_height = 600;

    projection_t pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          quiet_phase = 0;
    int          sink_stall = 0;

    function automatic longint sat_to(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic projection_t project_sprite(logic signed [31:0] sx,
                                                   logic signed [31:0] sy,
                                                   logic signed [11:0] voff);
        projection_t r;
        longint rx, ry, det, tx, ty, half, sz, centre, bottom, top, mag, p;
        longint unsigned a, d, ip, rem, fr, q;
        bit inexact;
        r = '0;
        rx = longint'(sx) - longint'(cam_pos_x);
        ry = longint'(sy) - longint'(cam_pos_y);
        det = longint'(cam_plane_x) * cam_dir_y - longint'(cam_dir_x) * cam_plane_y;
        if (det == 0) return r;
        tx = ((longint'(cam_dir_y) * rx - longint'(cam_dir_x) * ry) * 16384) / det;
        ty = ((longint'(cam_plane_x) * ry - longint'(cam_plane_y) * rx) * 16384) / det;
        if (ty < (longint'(TILE) * 65536 + 9) / 10) return r;
        half = scr_width >> 1;
        a = tx < 0 ? -tx : tx;
        d = ty;
        ip = a / d;
        inexact = 0;
        if (ip >= (64'd1 << 30)) begin
            mag = longint'(1) << 42;
            inexact = 1;
        end else begin
            // exact floor(half * frac) by long division
            fr = a % d;
            q = 0;
            rem = 0;
            for (int i = 11; i >= 0; i--) begin
                q <<= 1;
                if (rem >= d - rem) begin
                    rem = rem - (d - rem);
                    q++;
                end else rem <<= 1;
                if (half[i]) begin
                    if (rem >= d - fr) begin
                        rem = rem - (d - fr);
                        q++;
                    end else rem += fr;
                end
            end
            inexact = rem != 0;
            mag = half * longint'(ip) + longint'(q);
        end
        if (half == 0) centre = 0;
        else if (tx >= 0) centre = half + mag;
        else begin
            p = mag + (inexact ? 1 : 0);
            centre = (half - p >= 0) ? half - p : half - mag;
        end
        sz = longint'((longint'(scr_height) * TILE * 65536) / d);
        bottom = longint'(scr_height >> 1) + voff + sz / 2;
        top = bottom - sz;
        r.visible       = 1'b1;
        r.depth         = 32'(sat_to(ty, -64'sd2147483648, 64'sd2147483647));
        r.center_column = 16'(sat_to(centre, -32768, 32767));
        r.first_column  = 16'(sat_to(centre - sz / 2, -32768, 32767));
        r.end_column    = 16'(sat_to(centre + sz / 2, -32768, 32767));
        r.top_row       = 16'(sat_to(top, -32768, 32767));
        r.bottom_row    = 16'(sat_to(bottom, -32768, 32767));
        r.sprite_size   = 15'(sat_to(sz, 0, 32767));
        return r;
    endfunction

    task automatic write_register(rsp_pkg::rsp_reg_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rsp_pkg::REG_DIR_X:    cam_dir_x = value[15:0];
            rsp_pkg::REG_DIR_Y:    cam_dir_y = value[15:0];
            rsp_pkg::REG_PLANE_X:  cam_plane_x = value[15:0];
            rsp_pkg::REG_PLANE_Y:  cam_plane_y = value[15:0];
            rsp_pkg::REG_CAMERA_X: cam_pos_x = value;
            rsp_pkg::REG_CAMERA_Y: cam_pos_y = value;
            rsp_pkg::REG_WIDTH:    scr_width = value[11:0];
            rsp_pkg::REG_HEIGHT:   scr_height = value[11:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // one sprite transaction, outside the quiet phase sometimes with a random gap ahead of it
    task automatic send_sprite(logic signed [31:0] sx, logic signed [31:0] sy,
                               logic signed [11:0] voff, bit typed, projection_t want);
        projection_t p;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, voff, sy, sx};
        do @(posedge aclk); while (!s_tready);
        p = project_sprite(sx, sy, voff);
        pending_results.push_back(typed ? want : p);
    endtask

    always @(posedge aclk) begin
        projection_t got, want;
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[63:48], m_tdata[79:64],
                   m_tdata[95:80], m_tdata[111:96], m_tdata[126:112]};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp vis=%b dep=%h cc=%h fc=%h ec=%h tr=%h br=%h sz=%h",
                            want.visible, want.depth, want.center_column, want.first_column,
                            want.end_column, want.top_row, want.bottom_row, want.sprite_size);
                        $display("          got vis=%b dep=%h cc=%h fc=%h ec=%h tr=%h br=%h sz=%h",
                            got.visible, got.depth, got.center_column, got.first_column,
                            got.end_column, got.top_row, got.bottom_row, got.sprite_size);
                    end
                end
            end
        end
        // sink idling in bursts
        if (quiet_phase) m_tready <= 1'b1;
        else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            sink_stall <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else m_tready <= 1'b1;
    end

    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 65536 * 40)) - 65536 * 40;
            default: return $signed($urandom_range(0, 2 * 65536 * 400)) - 65536 * 400;
        endcase
    endfunction

    sprite_row_t directed[] ;
    projection_t none;

    initial begin
        none = '0;
        directed = '{
            // straight ahead: dir (1,0), depth = sx
            '{32'sh0004_0000, 0, 0, 0, none},
            '{32'sh0001_0000, 0, 12'sh7ff, 0, none},
            '{32'sh0001_0000, 0, 12'sh800, 0, none},
            // behind the camera and below the near limit read invisible
            '{-32'sh0001_0000, 0, 0, 1, none},
            '{0, 0, 0, 1, none},
            '{32'sd419429, 0, 0, 1, none},
            '{32'sd419430, 0, 0, 0, none},
            '{32'h7fffffff, 32'h7fffffff, 12'sh7ff, 0, none},
            '{32'h80000000, 32'h80000000, 12'sh800, 1, none},
            '{32'h7fffffff, 32'h80000000, 0, 0, none},
            '{32'sd419430, 32'h7fffffff, 0, 0, none},
            '{32'sd419430, 32'h80000000, 0, 0, none},
            '{32'h0010_0000, 32'hfff8_0000, 12'sh123, 0, none},
            '{32'h0010_0000, 32'h0008_0000, 12'sh9ab, 0, none}
        };
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        foreach (directed[i])
            send_sprite(directed[i].sx, directed[i].sy, directed[i].voff,
                        directed[i].typed, directed[i].want);
        wait_drained();
        // zero determinant
        write_register(rsp_pkg::REG_PLANE_Y, 0);
        send_sprite(32'h0004_0000, 0, 0, 1, none);
        send_sprite(32'h7fff_0000, 32'h1234_0000, 0, 1, none);
        wait_drained();
        // extreme and zero screen sizes
        write_register(rsp_pkg::REG_PLANE_Y, 32'h7fff);
        write_register(rsp_pkg::REG_WIDTH, 1);
        write_register(rsp_pkg::REG_HEIGHT, 0);
        send_sprite(32'h0004_0000, 32'h0001_0000, 0, 0, none);
        wait_drained();
        write_register(rsp_pkg::REG_WIDTH, 4095);
        write_register(rsp_pkg::REG_HEIGHT, 4095);
        send_sprite(32'sd419430, 32'h7000_0000, 12'sh7ff, 0, none);
        send_sprite(32'sd419430, 32'h9000_0000, 12'sh800, 0, none);
        wait_drained();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5) begin
                write_register(rsp_pkg::REG_DIR_X, 32'h8000);
                write_register(rsp_pkg::REG_DIR_Y, 32'h7fff);
                write_register(rsp_pkg::REG_PLANE_X, 32'h7fff);
                write_register(rsp_pkg::REG_PLANE_Y, 32'h8000);
                write_register(rsp_pkg::REG_CAMERA_X, 32'h8000_0000);
                write_register(rsp_pkg::REG_CAMERA_Y, 32'h7fff_ffff);
            end else begin
                write_register(rsp_pkg::REG_DIR_X, $urandom);
                write_register(rsp_pkg::REG_DIR_Y, $urandom);
                write_register(rsp_pkg::REG_PLANE_X, $urandom);
                write_register(rsp_pkg::REG_PLANE_Y, $urandom);
                write_register(rsp_pkg::REG_CAMERA_X,
                    $signed($urandom_range(0, 65536 * 200)) - 65536 * 100);
                write_register(rsp_pkg::REG_CAMERA_Y, phase == 4 ? $urandom :
                    $signed($urandom_range(0, 65536 * 200)) - 65536 * 100);
            end
            write_register(rsp_pkg::REG_WIDTH, $urandom_range(0, 4095));
            write_register(rsp_pkg::REG_HEIGHT, $urandom_range(0, 4095));
            if (phase == 4) quiet_phase = 1;
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                send_sprite(rand_pos() + cam_pos_x, rand_pos() + cam_pos_y, 12'($urandom),
                            0, none);
            end
            wait_drained();
        end
        if (mismatches == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
